[rtl/core/mtes_pkg.sv]
// Shared types, constants and helpers for the multi-token event scheduler.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package mtes_pkg;

   localparam int TOKENS_DEFAULT = 4;
   localparam int TOKEN_W        = 2;
   localparam int AMOUNT_W       = 31;
   localparam int TIME_W         = 32;

   // largest positive deadline; cap of the earliest-deadline minimum
   localparam logic [TIME_W-1:0] DEADLINE_CEILING = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      ACT_ADVANCE  = 2'd0,
      ACT_RESYNC   = 2'd1,
      ACT_SCHEDULE = 2'd2,
      ACT_REBASE   = 2'd3
   } action_type;

   typedef struct packed {
      action_type            action;
      logic [TOKEN_W-1:0]    token;
      logic [AMOUNT_W-1:0]   amount;
   } cmd_type;

   typedef struct packed {
      logic [AMOUNT_W-1:0]   elapsed;
      logic                  event_pending;
      logic [TIME_W-1:0]     earliest_deadline;
   } res_type;

   // signed 32-bit a < b on raw bit patterns
   function automatic logic signed_less(input logic [TIME_W-1:0] a,
                                        input logic [TIME_W-1:0] b);
      signed_less = $signed(a) < $signed(b);
   endfunction

endpackage

`default_nettype wire

[rtl/core/mtes_min_tree.sv]
// Balanced signed-minimum tree over all deadlines, capped at DEADLINE_CEILING.
// Depends on mtes_pkg.
`default_nettype none

module mtes_min_tree
   import mtes_pkg::*;
#(
   parameter int TOKENS = TOKENS_DEFAULT
) (
   input  wire logic [TOKENS-1:0][TIME_W-1:0] values,
   output logic      [TIME_W-1:0]             min_value
);

   localparam int LEVELS = $clog2(TOKENS);
   localparam int LEAVES = 1 << LEVELS;

   logic [LEVELS:0][LEAVES-1:0][TIME_W-1:0] lvl;

   always_comb begin
      for (int l = 0; l <= LEVELS; l++) begin
         for (int j = 0; j < LEAVES; j++) begin
            lvl[l][j] = DEADLINE_CEILING;
         end
      end
      for (int j = 0; j < TOKENS; j++) begin
         lvl[0][j] = values[j];
      end
      // pair up neighbours, one level at a time
      for (int l = 1; l <= LEVELS; l++) begin
         for (int j = 0; j < (LEAVES >> l); j++) begin
            lvl[l][j] = signed_less(lvl[l-1][2*j+1], lvl[l-1][2*j]) ?
                        lvl[l-1][2*j+1] : lvl[l-1][2*j];
         end
      end
      min_value = signed_less(lvl[LEVELS][0], DEADLINE_CEILING) ?
                  lvl[LEVELS][0] : DEADLINE_CEILING;
   end

endmodule

`default_nettype wire

[rtl/core/mtes_state.sv]
// Scheduler state (counter, stamps, deadlines, earliest) and the step logic.
// Depends on mtes_pkg and mtes_min_tree.
`default_nettype none

module mtes_state
   import mtes_pkg::*;
#(
   parameter int TOKENS = TOKENS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire cmd_type cmd,
   output res_type      res
);

   logic [TIME_W-1:0]             cycle_ff, cycle_in;
   logic [TIME_W-1:0]             earliest_ff, earliest_in;
   logic [TOKENS-1:0][TIME_W-1:0] stamp_ff, stamp_in;
   logic [TOKENS-1:0][TIME_W-1:0] deadline_ff, deadline_in;
   logic [TOKENS-1:0][TIME_W-1:0] sched_deadline;
   logic [TIME_W-1:0]             sched_min;
   logic [TOKENS-1:0]             hit;
   logic                          hit_any;
   logic [TIME_W-1:0]             stamp_sel;
   logic [TIME_W-1:0]             since;
   logic                          since_pos;
   logic [TIME_W-1:0]             target;

   // decode the token and pick its stamp
   always_comb begin
      hit_any   = 1'b0;
      stamp_sel = '0;
      for (int i = 0; i < TOKENS; i++) begin
         hit[i] = (32'(cmd.token) == 32'(i));
         if (hit[i]) begin
            hit_any   = 1'b1;
            stamp_sel = stamp_ff[i];
         end
      end
   end

   assign since     = cycle_ff - stamp_sel;
   assign since_pos = (since != '0) && !since[TIME_W-1];
   assign target    = cycle_ff + {1'b0, cmd.amount};

   always_comb begin
      for (int i = 0; i < TOKENS; i++) begin
         sched_deadline[i] = hit[i] ? target : deadline_ff[i];
      end
   end

   mtes_min_tree #(
      .TOKENS (TOKENS)
   ) u_min_tree (
      .values    (sched_deadline),
      .min_value (sched_min)
   );

   always_comb begin
      cycle_in    = cycle_ff;
      earliest_in = earliest_ff;
      stamp_in    = stamp_ff;
      deadline_in = deadline_ff;
      res.elapsed = '0;
      unique case (cmd.action)
         ACT_ADVANCE: begin
            cycle_in = cycle_ff + {1'b0, cmd.amount};
         end
         ACT_RESYNC: begin
            if (hit_any && since_pos) begin
               for (int i = 0; i < TOKENS; i++) begin
                  if (hit[i]) begin
                     stamp_in[i] = cycle_ff;
                  end
               end
               res.elapsed = since[AMOUNT_W-1:0];
            end
         end
         ACT_SCHEDULE: begin
            if (hit_any) begin
               deadline_in = sched_deadline;
               earliest_in = sched_min;
            end
         end
         ACT_REBASE: begin
            for (int i = 0; i < TOKENS; i++) begin
               stamp_in[i]    = stamp_ff[i] - cycle_ff;
               deadline_in[i] = deadline_ff[i] - cycle_ff;
            end
            earliest_in = earliest_ff - cycle_ff;
            cycle_in    = '0;
         end
         default: begin
            cycle_in = cycle_ff;
         end
      endcase
      res.event_pending     = !signed_less(cycle_in, earliest_in);
      res.earliest_deadline = earliest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ff    <= '0;
         earliest_ff <= '0;
         stamp_ff    <= '0;
         deadline_ff <= '0;
      end else if (step_en) begin
         cycle_ff    <= cycle_in;
         earliest_ff <= earliest_in;
         stamp_ff    <= stamp_in;
         deadline_ff <= deadline_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/multi_token_event_scheduler_top.sv]
// Top level of the multi-token event scheduler: input register, result register,
// handshakes and checks. Depends on mtes_pkg and mtes_state.
`default_nettype none

//  channel  | ports                                                          | direction
//  ---------+----------------------------------------------------------------+----------
//  request  | req_valid, req_ready, req_action, req_token, req_amount        | in
//  response | rsp_valid, rsp_ready, rsp_elapsed, rsp_event_pending, rsp_earliest_deadline | out
//
// One transfer per cycle sustained while rsp_ready stays high: a request lands in
// the input register, then the step runs through the state logic into the result
// register once that register is free, and the response is offered from there.
// Reset (synchronous) zeroes the counter, every stamp, every deadline and earliest;
// no clearing pass is needed.
// A stalled response holds the result register; the input register then holds its
// request, and req_ready drops only when both registers are full and rsp_ready is low.

module multi_token_event_scheduler_top
   import mtes_pkg::*;
#(
   parameter int TOKENS = TOKENS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_action,
   input  wire logic [TOKEN_W-1:0]         req_token,
   input  wire logic [AMOUNT_W-1:0]        req_amount,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [AMOUNT_W-1:0]             rsp_elapsed,
   output logic                            rsp_event_pending,
   output logic signed [TIME_W-1:0]        rsp_earliest_deadline
);

   // input register
   logic    in_valid_ff, in_valid_in;
   cmd_type in_cmd_ff;
   // result register
   logic    out_valid_ff, out_valid_in;
   res_type out_res_ff;

   res_type step_res;
   logic    out_free;
   logic    step_fire;
   logic    req_fire;

   // advance the held request when the result register can take it
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step_fire = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step_fire;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (step_fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = step_fire ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff.action <= action_type'(req_action);
         in_cmd_ff.token  <= req_token;
         in_cmd_ff.amount <= req_amount;
      end
      if (step_fire) begin
         out_res_ff <= step_res;
      end
   end

   mtes_state #(
      .TOKENS (TOKENS)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_fire),
      .cmd     (in_cmd_ff),
      .res     (step_res)
   );

   assign rsp_valid             = out_valid_ff;
   assign rsp_elapsed           = out_res_ff.elapsed;
   assign rsp_event_pending     = out_res_ff.event_pending;
   assign rsp_earliest_deadline = $signed(out_res_ff.earliest_deadline);

   // a request taken is always held in the input register next cycle
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted request not held in input register");

   // a blocked step must keep its request untouched
   a_step_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_cmd_ff)))
      else $error("stalled request lost or changed");

   // only a resync can report elapsed cycles
   a_elapsed_zero: assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_cmd_ff.action != ACT_RESYNC) |=> (rsp_valid && rsp_elapsed == '0))
      else $error("non-resync step reported elapsed cycles");

endmodule

`default_nettype wire

[tb/sv/sched_checker.sv]
`timescale 1ns / 100ps
// Checker for the multi-token event scheduler: watches both channels, predicts every
// response from its own copy of the counter, stamps and deadlines, and compares.
// Depends on mtes_pkg; instantiated by tb beside the block.

module sched_checker
   import mtes_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire logic [1:0]             req_action,
   input  wire logic [TOKEN_W-1:0]     req_token,
   input  wire logic [AMOUNT_W-1:0]    req_amount,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire logic [AMOUNT_W-1:0]    rsp_elapsed,
   input  wire logic                   rsp_event_pending,
   input  wire logic signed [TIME_W-1:0] rsp_earliest_deadline,
   output int                          fail_count,
   output int                          waiting
);

   logic [TIME_W-1:0] tick;
   logic [TIME_W-1:0] stamp  [TOKENS_DEFAULT];
   logic [TIME_W-1:0] due_at [TOKENS_DEFAULT];
   logic [TIME_W-1:0] soonest;
   res_type           due_results [$];
   int                misses;

   // Apply one action to the shadow state and work out the response it earns.
   task automatic run_step(input action_type act, input logic [TOKEN_W-1:0] tok,
                           input logic [AMOUNT_W-1:0] amt, output res_type r);
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] lowest;
      r = '0;
      case (act)
         ACT_ADVANCE: begin
            tick = tick + {1'b0, amt};
         end
         ACT_RESYNC: begin
            if (int'(tok) < TOKENS_DEFAULT) begin
               gap = tick - stamp[tok];
               if ($signed(gap) > 0) begin
                  stamp[tok] = tick;
                  r.elapsed  = gap[AMOUNT_W-1:0];
               end
            end
         end
         ACT_SCHEDULE: begin
            if (int'(tok) < TOKENS_DEFAULT) begin
               due_at[tok] = tick + {1'b0, amt};
               lowest = DEADLINE_CEILING;
               for (int i = 0; i < TOKENS_DEFAULT; i++)
                  if ($signed(due_at[i]) < $signed(lowest))
                     lowest = due_at[i];
               soonest = lowest;
            end
         end
         default: begin
            for (int i = 0; i < TOKENS_DEFAULT; i++) begin
               stamp[i]  = stamp[i] - tick;
               due_at[i] = due_at[i] - tick;
            end
            soonest = soonest - tick;
            tick    = '0;
         end
      endcase
      r.event_pending     = !($signed(tick) < $signed(soonest));
      r.earliest_deadline = soonest;
   endtask

   always @(posedge clock) begin : watch
      res_type want;
      res_type fresh;
      if (reset) begin
         tick    = '0;
         soonest = '0;
         for (int i = 0; i < TOKENS_DEFAULT; i++) begin
            stamp[i]  = '0;
            due_at[i] = '0;
         end
         due_results.delete();
         misses = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               misses++;
               if (misses <= 10)
                  $display("%0t: response with none due: elapsed=%0d pending=%0b earliest=%0d",
                           $realtime, rsp_elapsed, rsp_event_pending, rsp_earliest_deadline);
            end else begin
               want = due_results.pop_front();
               if (rsp_elapsed !== want.elapsed
                   || rsp_event_pending !== want.event_pending
                   || rsp_earliest_deadline !== want.earliest_deadline) begin
                  misses++;
                  if (misses <= 10)
                     $display("%0t: mismatch exp %0d/%0b/%0d got %0d/%0b/%0d", $realtime,
                              want.elapsed, want.event_pending,
                              $signed(want.earliest_deadline),
                              rsp_elapsed, rsp_event_pending, rsp_earliest_deadline);
               end
            end
         end
         if (req_valid && req_ready) begin
            run_step(action_type'(req_action), req_token, req_amount, fresh);
            due_results.push_back(fresh);
         end
      end
      fail_count <= misses;
      waiting    <= due_results.size();
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the multi-token event scheduler: clock, reset, stimulus and verdict.
// Depends on mtes_pkg, multi_token_event_scheduler_top and sched_checker.

module tb
   import mtes_pkg::*;
();

   localparam int HOLD_OFF_CYCLES = 60;   // long receiver stall to fill the block
   localparam int SETTLE_CYCLES   = 8;    // settle time before the verdict

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [1:0]                req_action;
   logic [TOKEN_W-1:0]        req_token;
   logic [AMOUNT_W-1:0]       req_amount;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [AMOUNT_W-1:0]       rsp_elapsed;
   logic                      rsp_event_pending;
   logic signed [TIME_W-1:0]  rsp_earliest_deadline;

   int fail_count;
   int waiting;

   // Chance, in percent, of starting an idle burst before a transfer; zero turns it off.
   int gap_pct;
   int stall_pct;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit hold_off_now;

   multi_token_event_scheduler_top #(.TOKENS(TOKENS_DEFAULT)) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_token             (req_token),
      .req_amount            (req_amount),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_elapsed           (rsp_elapsed),
      .rsp_event_pending     (rsp_event_pending),
      .rsp_earliest_deadline (rsp_earliest_deadline)
   );

   // The checker sees exactly what the block sees and keeps the tally.
   sched_checker u_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_token             (req_token),
      .req_amount            (req_amount),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_elapsed           (rsp_elapsed),
      .rsp_event_pending     (rsp_event_pending),
      .rsp_earliest_deadline (rsp_earliest_deadline),
      .fail_count            (fail_count),
      .waiting               (waiting)
   );

   // 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin : watchdog
      #400_000;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver side: mostly ready, with short random stalls, and one long hold-off on
   // request. The long one is counted here so the sender keeps offering meanwhile.
   initial begin : rsp_side
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_now && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_done = 1'b1;
            rsp_ready <= 1'b1;
         end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one request and hold it until the transfer. Valid is only dropped when an
   // idle burst is taken, so it is never lowered and raised within one time step.
   task automatic offer(input action_type act, input logic [TOKEN_W-1:0] tok,
                        input logic [AMOUNT_W-1:0] amt);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_token  <= tok;
      req_amount <= amt;
      do @(posedge clock); while (!req_ready);
   endtask

   // Random request: small advances and delays dominate so that deadlines are met and
   // missed often, with zeros, all-ones and full-width values mixed in to cover every
   // amount bit and to wrap the counter now and then.
   task automatic offer_random();
      action_type          act;
      logic [AMOUNT_W-1:0] amt;
      case ($urandom_range(0, 15))
         0:             act = ACT_REBASE;
         1, 2, 3, 4, 5: act = ACT_ADVANCE;
         6, 7, 8, 9:    act = ACT_RESYNC;
         default:       act = ACT_SCHEDULE;
      endcase
      case ($urandom_range(0, 9))
         0:       amt = '0;
         1:       amt = '1;
         2, 3:    amt = AMOUNT_W'($urandom());
         default: amt = AMOUNT_W'($urandom_range(0, 40));
      endcase
      offer(act, TOKEN_W'($urandom_range(0, 3)), amt);
   endtask

   // Drop valid and hold until every outstanding response has been taken. The extra
   // edge lets the checker's count catch up with the last transfer.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_action <= ACT_ADVANCE;
      req_token  <= '0;
      req_amount <= '0;
      gap_pct      = 20;
      stall_pct    = 20;
      hold_off_now = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: resync with nothing elapsed, extreme delays and advances,
      // deadlines that wrap negative, a resync that sees a negative gap after the
      // counter wraps, rebases with stamps and deadlines on both sides of the counter.
      offer(ACT_RESYNC,   2'd0, '0);
      offer(ACT_SCHEDULE, 2'd0, '1);
      offer(ACT_SCHEDULE, 2'd1, '0);
      offer(ACT_ADVANCE,  2'd0, '0);
      offer(ACT_ADVANCE,  2'd3, '1);
      offer(ACT_RESYNC,   2'd1, '0);
      offer(ACT_SCHEDULE, 2'd2, '1);
      offer(ACT_ADVANCE,  2'd1, '1);
      offer(ACT_RESYNC,   2'd0, '0);
      offer(ACT_RESYNC,   2'd3, '1);
      offer(ACT_REBASE,   2'd2, 31'h5555_5555);
      offer(ACT_ADVANCE,  2'd2, 31'd3);
      offer(ACT_RESYNC,   2'd2, '0);
      offer(ACT_RESYNC,   2'd2, '0);
      offer(ACT_SCHEDULE, 2'd3, 31'd5);
      offer(ACT_SCHEDULE, 2'd0, '0);
      offer(ACT_SCHEDULE, 2'd1, '1);
      offer(ACT_SCHEDULE, 2'd2, 31'h2AAA_AAAA);
      offer(ACT_ADVANCE,  2'd0, 31'd10);
      offer(ACT_REBASE,   2'd1, '0);
      offer(ACT_RESYNC,   2'd3, '0);
      offer(ACT_SCHEDULE, 2'd3, '0);

      // Random traffic with idling on both sides.
      repeat (250) offer_random();

      // Sender pause: let the block empty completely.
      drain();

      // Long receiver hold-off while requests keep coming, so the block stalls its input.
      hold_off_now = 1'b1;
      gap_pct      = 0;
      repeat (150) offer_random();

      // Heavier idling on both sides.
      gap_pct   = 30;
      stall_pct = 40;
      repeat (100) offer_random();

      // Closing stretch at full rate: no idling at all.
      gap_pct   = 0;
      stall_pct = 0;
      repeat (150) offer_random();

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
